[rtl/core/erg_pkg.sv]
// shared types, microcode table and constants for the euclidean rhythm generator
`default_nettype none

package erg_pkg;

	// largest supported step count and fixed field widths
	localparam int MAX_STEPS_DEF = 64;
	localparam int FIELD_W       = 7;
	localparam int PATTERN_W     = 64;

	// microcode address width and step addresses
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] STEP_CHECK = 3'd1;
	localparam logic [PC_W-1:0] STEP_PAIR  = 3'd2;
	localparam logic [PC_W-1:0] STEP_CAT_X = 3'd3;
	localparam logic [PC_W-1:0] STEP_CAT_Y = 3'd4;
	localparam logic [PC_W-1:0] STEP_EMIT  = 3'd5;
	localparam logic [PC_W-1:0] STEP_WRAP  = 3'd6;

	// input beat
	typedef struct packed {
		logic [FIELD_W-1:0] steps;
		logic [FIELD_W-1:0] beats;
	} in_t;

	// output beat
	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic                 bad_request;
	} out_t;

	// datapath operation selected by a control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_PAIR,
		OP_CAT_X,
		OP_CAT_Y,
		OP_EMIT
	} op_t;

	// jump condition selected by a control word
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_NEVER,
		COND_NO_INPUT,
		COND_BAD,
		COND_PAIR,
		COND_X_LEFT,
		COND_Y_LEFT,
		COND_OUT_BUSY
	} cond_t;

	// one microcode word: operation, jump condition, jump target
	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic bad;
		logic pair_go;
		logic x_left;
		logic y_left;
	} dp_status_t;

	// microcode rom: jump to target when the condition holds, else fall through
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			STEP_IDLE:  w = '{op: OP_LOAD,  cond: COND_NO_INPUT, target: STEP_IDLE};
			STEP_CHECK: w = '{op: OP_NOP,   cond: COND_BAD,      target: STEP_EMIT};
			STEP_PAIR:  w = '{op: OP_PAIR,  cond: COND_PAIR,     target: STEP_PAIR};
			STEP_CAT_X: w = '{op: OP_CAT_X, cond: COND_X_LEFT,   target: STEP_CAT_X};
			STEP_CAT_Y: w = '{op: OP_CAT_Y, cond: COND_Y_LEFT,   target: STEP_CAT_Y};
			STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY, target: STEP_EMIT};
			STEP_WRAP:  w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_IDLE};
			default:    w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/core/erg_seq.sv]
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module erg_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                out_busy,
	input  wire erg_pkg::dp_status_t status,
	output erg_pkg::op_t             op
);

	logic [erg_pkg::PC_W-1:0] pc_q;
	logic [erg_pkg::PC_W-1:0] pc_d;
	erg_pkg::ctrl_word_t      word;
	logic                     take_jump;

	// fetch the control word and evaluate its condition
	always_comb begin
		word = erg_pkg::ucode(pc_q);
		case (word.cond)
			erg_pkg::COND_ALWAYS:   take_jump = 1'b1;
			erg_pkg::COND_NEVER:    take_jump = 1'b0;
			erg_pkg::COND_NO_INPUT: take_jump = !in_valid;
			erg_pkg::COND_BAD:      take_jump = status.bad;
			erg_pkg::COND_PAIR:     take_jump = status.pair_go;
			erg_pkg::COND_X_LEFT:   take_jump = status.x_left;
			erg_pkg::COND_Y_LEFT:   take_jump = status.y_left;
			erg_pkg::COND_OUT_BUSY: take_jump = out_busy;
			default:                take_jump = 1'b0;
		endcase
		pc_d = take_jump ? word.target : pc_q + 1'b1;
		op   = word.op;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= erg_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/erg_dp.sv]
// datapath: group registers, pairing unit and pattern concatenation
`default_nettype none

module erg_dp #(
	parameter int MaxSteps = erg_pkg::MAX_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire erg_pkg::op_t        op,
	input  wire logic                load,
	input  wire erg_pkg::in_t        req,
	output erg_pkg::dp_status_t      status,
	output logic [MaxSteps-1:0]      acc
);

	localparam int W  = MaxSteps;
	localparam int LW = $clog2(MaxSteps + 1);

	logic          bad_q;
	logic [W-1:0]  xbits_q, ybits_q, acc_q;
	logic [LW-1:0] xlen_q, ylen_q, xcnt_q, ycnt_q, pos_q;
	logic          bad_in;
	logic [erg_pkg::FIELD_W-1:0] rest_in;
	logic [W-1:0]  joined;

	// request check and remainder count
	assign bad_in  = (req.steps > erg_pkg::FIELD_W'(MaxSteps)) || (req.beats > req.steps);
	assign rest_in = req.steps - req.beats;

	// flags for the sequencer
	assign status.bad     = bad_q;
	assign status.pair_go = (xcnt_q > LW'(1)) && (ycnt_q > LW'(1));
	assign status.x_left  = (xcnt_q != '0);
	assign status.y_left  = (ycnt_q != '0);

	// x followed by y, first step in bit 0
	assign joined = xbits_q | (ybits_q << xlen_q);

	assign acc = acc_q;

	// bad flag is control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else if (load) begin
			bad_q <= bad_in;
		end
	end

	// group registers and accumulator
	always_ff @(posedge clk) begin
		case (op)
			erg_pkg::OP_LOAD: begin
				if (load) begin
					xbits_q <= W'(1);
					xlen_q  <= LW'(1);
					xcnt_q  <= req.beats[LW-1:0];
					ybits_q <= '0;
					ylen_q  <= LW'(1);
					ycnt_q  <= rest_in[LW-1:0];
					acc_q   <= '0;
					pos_q   <= '0;
				end
			end
			erg_pkg::OP_PAIR: begin
				if (status.pair_go) begin
					if (xcnt_q >= ycnt_q) begin
						xcnt_q  <= ycnt_q;
						ycnt_q  <= xcnt_q - ycnt_q;
						ybits_q <= xbits_q;
						ylen_q  <= xlen_q;
					end else begin
						ycnt_q <= ycnt_q - xcnt_q;
					end
					xbits_q <= joined;
					xlen_q  <= xlen_q + ylen_q;
				end
			end
			erg_pkg::OP_CAT_X: begin
				if (status.x_left) begin
					acc_q  <= acc_q | (xbits_q << pos_q);
					pos_q  <= pos_q + xlen_q;
					xcnt_q <= xcnt_q - 1'b1;
				end
			end
			erg_pkg::OP_CAT_Y: begin
				if (status.y_left) begin
					acc_q  <= acc_q | (ybits_q << pos_q);
					pos_q  <= pos_q + ylen_q;
					ycnt_q <= ycnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/euclidean_rhythm_generator.sv]
// top level of the euclidean rhythm generator
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data  (steps, beats)
// out      output     out_valid / out_ready  out_data (pattern, bad_request)
//
// one beat in gives one beat out; a request runs p pairing rounds and x + y
// concatenation steps (p + x + y <= steps), and a bad request goes from the
// check step straight to emit. the microcode sequencer runs one datapath step
// a cycle, except while it waits at idle for input or at emit for the output.
// reset puts the step counter at idle and empties the output register.
// a stalled output holds the sequencer at its emit step; the next request is
// taken while a result still waits in the output register.
`default_nettype none

module euclidean_rhythm_generator #(
	parameter int MaxSteps = erg_pkg::MAX_STEPS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire erg_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output erg_pkg::out_t      out_data
);

	erg_pkg::op_t        op;
	erg_pkg::dp_status_t status;
	logic [MaxSteps-1:0] acc;
	logic                in_fire;
	logic                emit;
	logic                out_valid_q;
	erg_pkg::out_t       out_q;

	// handshakes
	assign in_ready = (op == erg_pkg::OP_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign emit     = (op == erg_pkg::OP_EMIT) && !out_valid_q;

	// sequencer
	erg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_valid_q),
		.status   (status),
		.op       (op)
	);

	// datapath
	erg_dp #(
		.MaxSteps (MaxSteps)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.load   (in_fire),
		.req    (in_data),
		.status (status),
		.acc    (acc)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pattern     <= status.bad ? '0 : erg_pkg::PATTERN_W'(acc);
			out_q.bad_request <= status.bad;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer leaves idle right after taking a request
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("sequencer still ready after taking a request");

	// a result appears only after an emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(op == erg_pkg::OP_EMIT))
		else $error("output became valid without an emit step");

	// a refused request carries an empty pattern
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.bad_request) |-> (out_data.pattern == '0))
		else $error("bad request with nonzero pattern");

	// emit never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("waiting result overwritten");

endmodule

`default_nettype wire
